[rtl/tcsa_pkg.sv]
// Shared types, widths and constants for the trace cycle-stamp anchor.
// Used by every module of the block; no dependencies.

package tcsa_pkg;

    // request fields
    localparam int ACTION_W   = 2;
    localparam int HEADER_W   = 32;
    localparam int STAMP_W    = 32;
    localparam int S_DATA_W   = HEADER_W + STAMP_W;
    localparam int S_USER_W   = ACTION_W;

    // result fields
    localparam int TIME_W     = 64;
    localparam int WALL_W     = 63;
    localparam int RATE_W     = 31;
    localparam int CNT_OUT_W  = 32;
    localparam int M_FIELDS_W = 1 + TIME_W + WALL_W + 1 + 3 * CNT_OUT_W + 1;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_DATA_W - M_FIELDS_W;
    localparam int M_USER_W   = 1;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = WALL_W;

    localparam logic [CFG_ADDR_W-1:0] REG_RATE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WALL = 2'd1;

    localparam logic [RATE_W-1:0] RATE_RESET = 31'd19200000;

    // request kinds
    localparam logic [ACTION_W-1:0] ACT_RAW  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_END  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CONV = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_NONE = 2'd3;

    // result kinds
    localparam logic [M_USER_W-1:0] KIND_SUMMARY = 1'b0;
    localparam logic [M_USER_W-1:0] KIND_CONV    = 1'b1;

    // record header decode
    localparam int CLASS_LSB = 10;
    localparam int CLASS_W   = 5;
    localparam int TYPE_LSB  = 30;
    localparam int TYPE_W    = 2;

    localparam logic [CLASS_W-1:0] CLASS_CTRL = 5'd1;
    localparam logic [TYPE_W-1:0]  TYPE_CONT  = 2'b10;
    localparam logic [TYPE_W-1:0]  TYPE_END   = 2'b11;

    // stamp to ns conversion
    localparam int NS_W       = 30;
    localparam logic [NS_W-1:0] NS_PER_SEC = 30'd1000000000;
    localparam int PROD_W     = STAMP_W + NS_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    localparam int COUNT_BITS_DEFAULT = 32;

    typedef struct packed {
        logic take;   // request accepted this cycle
        logic mul;    // form product, load divider
        logic step;   // one quotient bit
        logic emit;   // load the result register
    } cmd_t;

    typedef struct packed {
        logic need_div;   // request at the port wants a quotient
    } status_t;

endpackage

[rtl/trace_cycle_stamp_anchor_core.sv]
// Top level of the trace cycle-stamp anchor: ports, controller, datapath.
// Depends on tcsa_pkg, tcsa_ctrl, tcsa_dp (and through it tcsa_div).
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------
//  s_*      | s_tvalid / s_tready | tuser action, tdata header + stamp
//  m_*      | m_tvalid / m_tready | tuser result kind, tdata summary/time
//  cfg_*    | cfg_valid/cfg_ready | cfg_addr register index, cfg_data
//
// Raw records are taken one per cycle unless an end-of-trace or convert
// request is in progress; those form the product, then run 62 divider steps
// (one quotient bit each). Failed scans and conversions without an anchor
// skip the divider. The next request is taken once the result is in the
// output register, even if m_tready is low. Reset clears all scan and anchor
// state at once; configuration returns to its reset values.

module trace_cycle_stamp_anchor_core #(
    parameter int COUNT_BITS = tcsa_pkg::COUNT_BITS_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tcsa_pkg::S_DATA_W-1:0]   s_tdata,   // header_word, cycle_stamp
    input  logic [tcsa_pkg::S_USER_W-1:0]   s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // ok, time_ns, end_ns, gap_found, after_gap_count, raw_count,
    // logical_count, past_collection, zero pad
    output logic [tcsa_pkg::M_DATA_W-1:0]   m_tdata,
    output logic [tcsa_pkg::M_USER_W-1:0]   m_tuser,   // result_kind
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcsa_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tcsa_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tcsa_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    tcsa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .action   (s_tuser),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    tcsa_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .action      (s_tuser),
        .header_word (s_tdata[HEADER_W-1:0]),
        .cycle_stamp (s_tdata[HEADER_W +: STAMP_W]),
        .cmd         (cmd),
        .status      (status),
        .out_user    (m_tuser),
        .out_data    (m_tdata)
    );

    // result register is only loaded when free or being drained
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result loaded over an unread result");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> m_tvalid)
        else $error("loaded result not presented");

    a_mul_then_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul |=> cmd.step)
        else $error("divider not stepped after load");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && (cmd.step || cmd.mul)))
        else $error("request port open while divider busy");

endmodule

[rtl/tcsa_div.sv]
// Restoring divider, one quotient bit per step.
// Depends on tcsa_pkg for operand widths.

module tcsa_div
(
    input  logic                         clk,
    input  logic                         load,
    input  logic                         step,
    input  logic [tcsa_pkg::PROD_W-1:0]  dividend,
    input  logic [tcsa_pkg::RATE_W-1:0]  divisor,
    output logic [tcsa_pkg::PROD_W-1:0]  quotient
);
    import tcsa_pkg::*;

    logic [RATE_W-1:0] rem_reg;
    logic [RATE_W-1:0] rem_next;
    logic [PROD_W-1:0] quo_reg;
    logic [PROD_W-1:0] quo_next;
    logic [RATE_W:0]   trial;
    logic [RATE_W:0]   diff;
    logic              fits;

    // remainder stays below the divisor, so it always fits RATE_W bits
    assign trial = {rem_reg, quo_reg[PROD_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign fits  = trial >= {1'b0, divisor};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (load)
        begin
            rem_next = '0;
            quo_next = dividend;
        end
        else if (step)
        begin
            rem_next = fits ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            quo_next = {quo_reg[PROD_W-2:0], fits};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;

endmodule

[rtl/tcsa_dp.sv]
// Datapath: configuration, scan tracking, anchor state, conversion arithmetic
// and the result register. Depends on tcsa_pkg and tcsa_div.

module tcsa_dp #(
    parameter int COUNT_BITS = tcsa_pkg::COUNT_BITS_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [tcsa_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [tcsa_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [tcsa_pkg::ACTION_W-1:0]    action,
    input  logic [tcsa_pkg::HEADER_W-1:0]    header_word,
    input  logic [tcsa_pkg::STAMP_W-1:0]     cycle_stamp,
    input  tcsa_pkg::cmd_t                   cmd,
    output tcsa_pkg::status_t                status,
    output logic [tcsa_pkg::M_USER_W-1:0]    out_user,
    output logic [tcsa_pkg::M_DATA_W-1:0]    out_data
);
    import tcsa_pkg::*;

    localparam int WIDE_BITS = (COUNT_BITS > CNT_OUT_W) ? COUNT_BITS : CNT_OUT_W;

    function automatic logic [CNT_OUT_W-1:0] sat32(input logic [WIDE_BITS-1:0] v);
        logic [WIDE_BITS-1:0] lim;
        lim = WIDE_BITS'({CNT_OUT_W{1'b1}});
        sat32 = (v > lim) ? {CNT_OUT_W{1'b1}} : v[CNT_OUT_W-1:0];
    endfunction

    // configuration
    logic [RATE_W-1:0]     cps_reg;
    logic [WALL_W-1:0]     wall_reg;

    // scan state
    logic [STAMP_W-1:0]    first_stamp_reg;
    logic [STAMP_W-1:0]    prev_stamp_reg;
    logic [RATE_W-1:0]     largest_gap_reg;
    logic [CNT_OUT_W-1:0]  gap_pos_reg;
    logic [STAMP_W-1:0]    stamp_before_gap_reg;
    logic [COUNT_BITS-1:0] raw_total_reg;
    logic [COUNT_BITS-1:0] logical_total_reg;

    // anchor state
    logic [STAMP_W-1:0]    anchor_stamp_reg;
    logic [WALL_W-1:0]     anchor_time_reg;
    logic [RATE_W-1:0]     captured_rate_reg;
    logic                  gap_flag_reg;
    logic                  anchor_valid_reg;

    // pending result, held while the quotient is formed
    logic [M_USER_W-1:0]   pend_kind_reg;
    logic                  pend_ok_reg;
    logic                  pend_past_reg;
    logic [CNT_OUT_W-1:0]  pend_after_reg;
    logic [CNT_OUT_W-1:0]  pend_raw_reg;
    logic [CNT_OUT_W-1:0]  pend_logical_reg;
    logic                  neg_reg;
    logic [STAMP_W-1:0]    mag_reg;

    logic [M_USER_W-1:0]   out_kind_reg;
    logic [M_DATA_W-1:0]   out_data_reg;

    logic                  is_raw;
    logic                  is_end;
    logic                  is_conv;
    logic [CLASS_W-1:0]    rec_class;
    logic [TYPE_W-1:0]     rec_type;
    logic                  rec_skip;
    logic [STAMP_W-1:0]    rec_delta;
    logic                  rec_bigger;
    logic [WIDE_BITS-1:0]  raw_wide;
    logic [WIDE_BITS-1:0]  logical_wide;
    logic                  scan_empty;
    logic                  end_fail;
    logic                  gap_hit;
    logic [STAMP_W-1:0]    end_anchor;
    logic [STAMP_W-1:0]    end_delta;
    logic [STAMP_W-1:0]    conv_delta;
    logic                  conv_past;
    logic [STAMP_W-1:0]    sel_delta;
    logic [PROD_W-1:0]     prod;
    logic [PROD_W-1:0]     quo;
    logic [TIME_W-1:0]     q_abs;
    logic [TIME_W-1:0]     q_signed;
    logic [TIME_W-1:0]     time_sum;
    logic [M_DATA_W-1:0]   packed_res;

    assign is_raw  = cmd.take && (action == ACT_RAW);
    assign is_end  = cmd.take && (action == ACT_END);
    assign is_conv = cmd.take && (action == ACT_CONV);

    assign rec_class  = header_word[CLASS_LSB +: CLASS_W];
    assign rec_type   = header_word[TYPE_LSB +: TYPE_W];
    assign rec_skip   = (rec_class == CLASS_CTRL) || (rec_type == TYPE_CONT) ||
                        (rec_type == TYPE_END);
    // wrapped delta read as signed; only a positive one can be a new gap
    assign rec_delta  = cycle_stamp - prev_stamp_reg;
    assign rec_bigger = !rec_delta[STAMP_W-1] && (rec_delta[RATE_W-1:0] > largest_gap_reg);

    assign raw_wide     = WIDE_BITS'(raw_total_reg);
    assign logical_wide = WIDE_BITS'(logical_total_reg);

    assign scan_empty = (logical_total_reg == '0);
    assign end_fail   = scan_empty || (cps_reg == '0);
    assign gap_hit    = (largest_gap_reg > cps_reg) && (gap_pos_reg != '0);
    assign end_anchor = gap_hit ? stamp_before_gap_reg : prev_stamp_reg;
    assign end_delta  = first_stamp_reg - end_anchor;
    assign conv_delta = cycle_stamp - anchor_stamp_reg;
    assign conv_past  = gap_flag_reg && !conv_delta[STAMP_W-1] &&
                        (conv_delta[RATE_W-1:0] > captured_rate_reg);
    assign sel_delta  = (action == ACT_END) ? end_delta : conv_delta;

    assign status.need_div = (action == ACT_END) ? !end_fail : anchor_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cps_reg  <= RATE_RESET;
            wall_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_addr)
                REG_RATE: cps_reg  <= cfg_data[RATE_W-1:0];
                REG_WALL: wall_reg <= cfg_data[WALL_W-1:0];
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_stamp_reg      <= '0;
            prev_stamp_reg       <= '0;
            largest_gap_reg      <= '0;
            gap_pos_reg          <= '0;
            stamp_before_gap_reg <= '0;
            raw_total_reg        <= '0;
            logical_total_reg    <= '0;
        end
        else if (is_raw)
        begin
            if (raw_total_reg != '1)
                raw_total_reg <= raw_total_reg + 1'b1;
            if (!rec_skip)
            begin
                if (scan_empty)
                    first_stamp_reg <= cycle_stamp;
                else if (rec_bigger)
                begin
                    largest_gap_reg      <= rec_delta[RATE_W-1:0];
                    gap_pos_reg          <= sat32(logical_wide);
                    stamp_before_gap_reg <= prev_stamp_reg;
                end
                prev_stamp_reg <= cycle_stamp;
                if (logical_total_reg != '1)
                    logical_total_reg <= logical_total_reg + 1'b1;
            end
        end
        else if (is_end)
        begin
            // end of trace starts a fresh scan
            first_stamp_reg      <= '0;
            prev_stamp_reg       <= '0;
            largest_gap_reg      <= '0;
            gap_pos_reg          <= '0;
            stamp_before_gap_reg <= '0;
            raw_total_reg        <= '0;
            logical_total_reg    <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_stamp_reg  <= '0;
            anchor_time_reg   <= '0;
            captured_rate_reg <= '0;
            gap_flag_reg      <= 1'b0;
            anchor_valid_reg  <= 1'b0;
        end
        else if (is_end)
        begin
            gap_flag_reg     <= !end_fail && gap_hit;
            anchor_valid_reg <= !end_fail;
            if (!end_fail)
            begin
                captured_rate_reg <= cps_reg;
                anchor_stamp_reg  <= end_anchor;
                anchor_time_reg   <= wall_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            neg_reg <= sel_delta[STAMP_W-1];
            mag_reg <= sel_delta[STAMP_W-1] ? (~sel_delta + 1'b1) : sel_delta;
            if (is_conv)
            begin
                pend_kind_reg    <= KIND_CONV;
                pend_ok_reg      <= anchor_valid_reg;
                pend_past_reg    <= conv_past;
                pend_after_reg   <= '0;
                pend_raw_reg     <= '0;
                pend_logical_reg <= '0;
            end
            else
            begin
                pend_kind_reg    <= KIND_SUMMARY;
                pend_ok_reg      <= !end_fail;
                pend_past_reg    <= 1'b0;
                pend_after_reg   <= gap_hit ?
                                    sat32(logical_wide - WIDE_BITS'(gap_pos_reg)) : '0;
                pend_raw_reg     <= sat32(raw_wide);
                pend_logical_reg <= sat32(logical_wide);
            end
        end
    end

    // constant multiply, registered by the divider load
    assign prod = PROD_W'(mag_reg) * PROD_W'(NS_PER_SEC);

    tcsa_div u_div
    (
        .clk      (clk),
        .load     (cmd.mul),
        .step     (cmd.step),
        .dividend (prod),
        .divisor  (captured_rate_reg),
        .quotient (quo)
    );

    // quotient magnitude truncates toward zero; restore the sign
    assign q_abs      = TIME_W'(quo);
    assign q_signed   = neg_reg ? (~q_abs + 1'b1) : q_abs;
    assign time_sum   = TIME_W'(anchor_time_reg) + q_signed;
    assign packed_res = {{M_PAD_W{1'b0}}, pend_past_reg, pend_logical_reg, pend_raw_reg,
                         pend_after_reg, gap_flag_reg, anchor_time_reg, time_sum, 1'b1};

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg <= pend_kind_reg;
            out_data_reg <= pend_ok_reg ? packed_res : '0;
        end
    end

    assign out_user = out_kind_reg;
    assign out_data = out_data_reg;

endmodule

[rtl/tcsa_ctrl.sv]
// Controller: request handshake, divider sequencing, result valid.
// Depends on tcsa_pkg for request kinds and command/status types.

module tcsa_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic [tcsa_pkg::ACTION_W-1:0]  action,
    input  logic                           m_tready,
    input  tcsa_pkg::status_t              status,
    output logic                           s_tready,
    output logic                           m_tvalid,
    output tcsa_pkg::cmd_t                 cmd
);
    import tcsa_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic [STEP_CNT_W-1:0] cnt_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic                  slot_free;

    assign slot_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = s_tvalid;
                if (s_tvalid && (action inside {ACT_END, ACT_CONV}))
                    state_next = status.need_div ? ST_MUL : ST_FIN;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_CNT_W'(DIV_STEPS - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                // wait here if the previous result is still unread
                cmd.emit = slot_free;
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid_next = cmd.emit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

[test/testbench.sv]
// Self-checking bench for trace_cycle_stamp_anchor_core: directed table, then random scans.
// Needs tcsa_pkg and the core RTL; predicts every summary and conversion in the bench itself.
`timescale 1ns / 100ps

module testbench;

    import tcsa_pkg::*;

    localparam int COUNT_BITS    = COUNT_BITS_DEFAULT;
    localparam int SETTLE_CYCLES = 80;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 165;

    localparam logic [63:0]           COUNT_MAX     = (64'd1 << COUNT_BITS) - 64'd1;
    localparam longint                NANOS_PER_SEC = 64'sd1000000000;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE     = 2'd2;

    // result field offsets within m_tdata
    localparam int OFS_OK      = 0;
    localparam int OFS_TIME    = OFS_OK + 1;
    localparam int OFS_END     = OFS_TIME + TIME_W;
    localparam int OFS_GAP     = OFS_END + WALL_W;
    localparam int OFS_AFTER   = OFS_GAP + 1;
    localparam int OFS_RAW     = OFS_AFTER + CNT_OUT_W;
    localparam int OFS_LOGICAL = OFS_RAW + CNT_OUT_W;
    localparam int OFS_PAST    = OFS_LOGICAL + CNT_OUT_W;

    typedef struct packed {
        logic        kind;
        logic        ok;
        logic [63:0] time_ns;
        logic [62:0] end_ns;
        logic        gap_found;
        logic [31:0] after_gap_count;
        logic [31:0] raw_count;
        logic [31:0] logical_count;
        logic        past_collection;
    } anchor_result_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [31:0]         header;
        logic [31:0]         stamp;
        logic                fixed;
        anchor_result_t      result;
    } stim_row_t;

    localparam anchor_result_t NO_RESULT = '0;
    localparam anchor_result_t SCAN_FAILED =
        '{KIND_SUMMARY, 1'b0, 64'd0, 63'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0};
    localparam anchor_result_t CONV_NO_ANCHOR =
        '{KIND_CONV, 1'b0, 64'd0, 63'd0, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0};

    // rows with a typed result are compared against it; the rest use the predictor
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{ACT_CONV, 32'h0000_0000, 32'h0000_0000, 1'b1, CONV_NO_ANCHOR},
        '{ACT_END,  32'h0000_0000, 32'h0000_0000, 1'b1, SCAN_FAILED},
        '{ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ACT_RAW,  32'h0000_0400, 32'h0000_0005, 1'b0, NO_RESULT},
        '{ACT_RAW,  32'h8000_0000, 32'h0000_0006, 1'b0, NO_RESULT},
        '{ACT_RAW,  32'hC000_0000, 32'h0000_0007, 1'b0, NO_RESULT},
        '{ACT_END,  32'h0000_0000, 32'h0000_0000, 1'b1, SCAN_FAILED},
        '{ACT_CONV, 32'h0000_0000, 32'h0000_1234, 1'b1, CONV_NO_ANCHOR},
        '{ACT_RAW,  32'h0000_0000, 32'h0000_0000, 1'b0, NO_RESULT},
        '{ACT_RAW,  32'h3FFF_FFFF, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ACT_RAW,  32'h7FFF_FBFF, 32'h7FFF_FFFF, 1'b0, NO_RESULT},
        '{ACT_RAW,  32'h4000_0800, 32'hFFFF_FFFE, 1'b0, NO_RESULT},
        '{ACT_RAW,  32'h0000_0000, 32'h0000_0063, 1'b0, NO_RESULT},
        '{ACT_END,  32'h0000_0000, 32'h0000_0000, 1'b0, NO_RESULT},
        '{ACT_CONV, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, NO_RESULT},
        '{ACT_CONV, 32'h0000_0000, 32'h8000_0000, 1'b0, NO_RESULT},
        '{ACT_CONV, 32'h0000_0000, 32'hFFFF_FFFE, 1'b0, NO_RESULT},
        '{ACT_RAW,  32'hFFFF_FFFF, 32'h1234_5678, 1'b0, NO_RESULT},
        '{ACT_RAW,  32'h8000_0000, 32'h0000_0000, 1'b0, NO_RESULT},
        '{ACT_RAW,  32'h0000_0000, 32'h0000_03E8, 1'b0, NO_RESULT},
        '{ACT_RAW,  32'h0000_0000, 32'h0000_07D0, 1'b0, NO_RESULT},
        '{ACT_END,  32'h0000_0000, 32'h0000_0000, 1'b0, NO_RESULT},
        '{ACT_CONV, 32'h0000_0000, 32'h0000_03E8, 1'b0, NO_RESULT},
        '{ACT_CONV, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
        '{ACT_END,  32'h0000_0000, 32'h0000_0000, 1'b1, SCAN_FAILED}
    };

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [S_USER_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    // configuration copy
    logic [30:0] rate_reg = RATE_RESET;
    logic [62:0] wall_reg = '0;

    // scan state
    logic [31:0] first_seen    = '0;
    logic [31:0] last_seen     = '0;
    logic [30:0] widest_gap    = '0;
    logic [31:0] gap_index     = '0;
    logic [31:0] stamp_at_gap  = '0;
    logic [63:0] records_seen  = '0;
    logic [63:0] events_kept   = '0;

    // anchor state
    logic [31:0] anchor_stamp  = '0;
    logic [63:0] anchor_ns     = '0;
    logic [30:0] anchor_rate   = '0;
    logic        anchor_gap    = 1'b0;
    logic        anchor_ok     = 1'b0;

    anchor_result_t awaited_results [$];

    logic [31:0] trail_stamp;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles    = 0;
    int          error_count    = 0;
    int          requests_sent  = 0;
    int          n_summaries    = 0;
    int          n_failed_scans = 0;
    int          n_gaps         = 0;
    int          n_conversions  = 0;
    int          n_past         = 0;

    trace_cycle_stamp_anchor_core #(
        .COUNT_BITS(COUNT_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic longint wrapped_delta(logic [31:0] a, logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return longint'($signed(d));
    endfunction

    function automatic logic [63:0] stamp_ns(logic [31:0] stamp, logic [31:0] anchor,
                                             logic [63:0] base, logic [30:0] rate);
        longint offset;
        offset = wrapped_delta(stamp, anchor) * NANOS_PER_SEC / longint'(rate);
        return base + offset;
    endfunction

    function automatic logic [31:0] clamp32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic void clear_scan();
        first_seen   = '0;
        last_seen    = '0;
        widest_gap   = '0;
        gap_index    = '0;
        stamp_at_gap = '0;
        records_seen = '0;
        events_kept  = '0;
    endfunction

    function automatic void apply_record(logic [31:0] header, logic [31:0] stamp);
        longint d;
        if (records_seen < COUNT_MAX)
            records_seen++;
        if (header[CLASS_LSB +: CLASS_W] == CLASS_CTRL ||
            header[TYPE_LSB +: TYPE_W] == TYPE_CONT ||
            header[TYPE_LSB +: TYPE_W] == TYPE_END)
            return;
        if (events_kept == 0)
            first_seen = stamp;
        else
        begin
            d = wrapped_delta(stamp, last_seen);
            if (d > longint'(widest_gap))
            begin
                widest_gap   = d[30:0];
                gap_index    = clamp32(events_kept);
                stamp_at_gap = last_seen;
            end
        end
        last_seen = stamp;
        if (events_kept < COUNT_MAX)
            events_kept++;
    endfunction

    function automatic void close_scan(output anchor_result_t res);
        res        = '0;
        res.kind   = KIND_SUMMARY;
        anchor_gap = 1'b0;
        if (events_kept == 0 || rate_reg == 0)
        begin
            anchor_ok = 1'b0;
            clear_scan();
            return;
        end
        anchor_rate  = rate_reg;
        anchor_stamp = last_seen;
        // anchor moves back to the event before a gap longer than one second
        if (widest_gap > rate_reg && gap_index > 0)
        begin
            anchor_gap          = 1'b1;
            anchor_stamp        = stamp_at_gap;
            res.after_gap_count = clamp32(events_kept - 64'(gap_index));
        end
        anchor_ns = {1'b0, wall_reg};
        anchor_ok = 1'b1;
        res.ok            = 1'b1;
        res.time_ns       = stamp_ns(first_seen, anchor_stamp, anchor_ns, anchor_rate);
        res.end_ns        = wall_reg;
        res.gap_found     = anchor_gap;
        res.raw_count     = clamp32(records_seen);
        res.logical_count = clamp32(events_kept);
        clear_scan();
    endfunction

    function automatic void convert_stamp(logic [31:0] stamp, output anchor_result_t res);
        res      = '0;
        res.kind = KIND_CONV;
        if (!anchor_ok || anchor_rate == 0)
            return;
        res.ok              = 1'b1;
        res.time_ns         = stamp_ns(stamp, anchor_stamp, anchor_ns, anchor_rate);
        res.end_ns          = anchor_ns[62:0];
        res.gap_found       = anchor_gap;
        res.past_collection = anchor_gap &&
                              (wrapped_delta(stamp, anchor_stamp) > longint'(anchor_rate));
    endfunction

    function automatic logic predict_request(logic [ACTION_W-1:0] action, logic [31:0] header,
                                             logic [31:0] stamp, output anchor_result_t res);
        res = '0;
        case (action)
            ACT_RAW:
            begin
                apply_record(header, stamp);
                return 1'b0;
            end
            ACT_END:
            begin
                close_scan(res);
                return 1'b1;
            end
            ACT_CONV:
            begin
                convert_stamp(stamp, res);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // ---------------------------------------------------------------- drivers

    // called at a falling edge; leaves s_tvalid high for a back-to-back request
    task automatic send_request(logic [ACTION_W-1:0] action, logic [31:0] header,
                                logic [31:0] stamp, logic fixed, anchor_result_t fixed_result);
        anchor_result_t res;
        logic           produced;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= {stamp, header};
        do
            @(posedge clk);
        while (!s_tready);
        produced = predict_request(action, header, stamp, res);
        if (produced)
            awaited_results.insert(awaited_results.size(), fixed ? fixed_result : res);
        if (action != ACT_NONE)
            requests_sent++;
        @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (addr)
            REG_RATE: rate_reg = data[30:0];
            REG_WALL: wall_reg = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // rate write carries junk above bit 30, which the block must drop
    task automatic configure(logic [30:0] rate, logic [62:0] wall);
        cfg_write(REG_RATE, {32'($urandom), rate});
        cfg_write(REG_WALL, wall);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        // a raw request may still be in flight with nothing awaited
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // mostly well-formed scans: records, end of trace, a few conversions
    task automatic run_random_phase(int target, logic pause_midway);
        int          start;
        int          n_records;
        int          n_convs;
        int unsigned pick;
        logic        paused;
        longint      span;
        longint      step;
        logic [31:0] header;
        logic [31:0] stamp;
        logic [31:0] conv_span;
        start       = requests_sent;
        paused      = 1'b0;
        trail_stamp = $urandom;
        while (requests_sent - start < target)
        begin
            if (pause_midway && !paused && (requests_sent - start) >= target / 2)
            begin
                paused = 1'b1;
                drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                send_request(ACTION_W'($urandom_range(ACT_RAW, ACT_NONE)), $urandom, $urandom,
                             1'b0, NO_RESULT);
                continue;
            end
            n_records = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            repeat (n_records)
            begin
                span = (rate_reg == 0) ? 64'sd1000 : longint'(rate_reg);
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    trail_stamp += $urandom_range(0, 32'(span / 4));
                else if (pick < 82)
                begin
                    step = span + $urandom_range(1, 32'(span / 2 + 1));
                    if (step > 64'sh7FFF_FFFF)
                        step = 64'sh7FFF_FFFF;
                    trail_stamp += step[31:0];
                end
                else if (pick < 92)
                    trail_stamp -= $urandom_range(0, 32'(span / 4));
                else
                    trail_stamp = $urandom;
                header = $urandom;
                pick   = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    if (header[CLASS_LSB +: CLASS_W] == CLASS_CTRL)
                        header[CLASS_LSB] = 1'b0;
                    header[TYPE_LSB + 1] = 1'b0;
                end
                else if (pick < 87)
                    header[CLASS_LSB +: CLASS_W] = CLASS_CTRL;
                else if (pick < 94)
                    header[TYPE_LSB +: TYPE_W] = TYPE_CONT;
                else
                    header[TYPE_LSB +: TYPE_W] = TYPE_END;
                send_request(ACT_RAW, header, trail_stamp, 1'b0, NO_RESULT);
            end
            send_request(ACT_END, $urandom, $urandom, 1'b0, NO_RESULT);
            n_convs = $urandom_range(0, 4);
            repeat (n_convs)
            begin
                conv_span = (anchor_rate == 0) ? 32'd1000 : {1'b0, anchor_rate};
                case ($urandom_range(0, 3))
                    0: stamp = anchor_stamp + $urandom_range(0, conv_span);
                    1: stamp = anchor_stamp - $urandom_range(0, conv_span);
                    2: stamp = anchor_stamp + conv_span + $urandom_range(1, conv_span);
                    default: stamp = $urandom;
                endcase
                send_request(ACT_CONV, $urandom, stamp, 1'b0, NO_RESULT);
            end
        end
    endtask

    // ---------------------------------------------------------------- result side

    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready    <= 1'b0;
                hold_cycles <= hold_cycles - 1;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (error_count < 40)
            $display("MISMATCH %s: got %h expected %h at %0t ns", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        anchor_result_t seen;
        anchor_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.kind            = m_tuser[0];
            seen.ok              = m_tdata[OFS_OK];
            seen.time_ns         = m_tdata[OFS_TIME +: TIME_W];
            seen.end_ns          = m_tdata[OFS_END +: WALL_W];
            seen.gap_found       = m_tdata[OFS_GAP];
            seen.after_gap_count = m_tdata[OFS_AFTER +: CNT_OUT_W];
            seen.raw_count       = m_tdata[OFS_RAW +: CNT_OUT_W];
            seen.logical_count   = m_tdata[OFS_LOGICAL +: CNT_OUT_W];
            seen.past_collection = m_tdata[OFS_PAST];
            if (awaited_results.size() == 0)
                report_mismatch("result with nothing awaited", 64'(seen.kind), '0);
            else
            begin
                want = awaited_results.pop_front();
                if (seen.kind !== want.kind)
                    report_mismatch("result_kind", 64'(seen.kind), 64'(want.kind));
                if (seen.ok !== want.ok)
                    report_mismatch("ok", 64'(seen.ok), 64'(want.ok));
                if (seen.time_ns !== want.time_ns)
                    report_mismatch("time_ns", seen.time_ns, want.time_ns);
                if (seen.end_ns !== want.end_ns)
                    report_mismatch("end_ns", 64'(seen.end_ns), 64'(want.end_ns));
                if (seen.gap_found !== want.gap_found)
                    report_mismatch("gap_found", 64'(seen.gap_found), 64'(want.gap_found));
                if (seen.after_gap_count !== want.after_gap_count)
                    report_mismatch("after_gap_count", 64'(seen.after_gap_count),
                                    64'(want.after_gap_count));
                if (seen.raw_count !== want.raw_count)
                    report_mismatch("raw_count", 64'(seen.raw_count), 64'(want.raw_count));
                if (seen.logical_count !== want.logical_count)
                    report_mismatch("logical_count", 64'(seen.logical_count),
                                    64'(want.logical_count));
                if (seen.past_collection !== want.past_collection)
                    report_mismatch("past_collection", 64'(seen.past_collection),
                                    64'(want.past_collection));
                if (want.kind == KIND_SUMMARY)
                begin
                    if (want.ok)
                        n_summaries++;
                    else
                        n_failed_scans++;
                    if (want.gap_found)
                        n_gaps++;
                end
                else
                begin
                    n_conversions++;
                    if (want.past_collection)
                        n_past++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_RAW;
        cfg_valid = 1'b0;
        cfg_addr  = REG_RATE;
        cfg_data  = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset configuration: rate 19.2 MHz, wall end at zero
        foreach (DIRECTED_ROWS[i])
            send_request(DIRECTED_ROWS[i].action, DIRECTED_ROWS[i].header,
                         DIRECTED_ROWS[i].stamp, DIRECTED_ROWS[i].fixed,
                         DIRECTED_ROWS[i].result);
        drain_results();

        configure(31'd1000, 63'({$urandom, $urandom}));
        run_random_phase(PHASE_ITEMS, 1'b0);
        drain_results();

        // largest rate and wall time
        configure(31'h7FFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF);
        send_idle_pct = 79;
        run_random_phase(PHASE_ITEMS, 1'b0);
        drain_results();

        // zero rate: every end of trace fails, conversions see no anchor
        configure(31'd0, 63'({$urandom, $urandom}));
        cfg_write(REG_SPARE, 63'({$urandom, $urandom}));
        send_idle_pct  = 0;
        recv_stall_pct = 79;
        run_random_phase(PHASE_ITEMS, 1'b0);
        drain_results();

        // long receiver hold-off so the block backs up into its input
        configure(RATE_RESET, 63'd0);
        send_idle_pct  = 22;
        recv_stall_pct = 22;
        hold_cycles   <= HOLD_CYCLES;
        run_random_phase(PHASE_ITEMS, 1'b0);
        drain_results();

        configure(31'($urandom_range(1, 5000)), 63'({$urandom, $urandom}));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_phase(PHASE_ITEMS, 1'b1);
        drain_results();

        configure(31'($urandom_range(1, 32'h7FFF_FFFF)), 63'({$urandom, $urandom}));
        recv_stall_pct = 79;
        run_random_phase(PHASE_ITEMS, 1'b0);
        drain_results();

        $display("Covered %0d requests: %0d summaries (%0d with a long gap), %0d failed scans,",
                 requests_sent, n_summaries, n_gaps, n_failed_scans);
        $display("  %0d conversions (%0d past collection), %0d mismatches.",
                 n_conversions, n_past, error_count);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Timeout with %0d results still awaited", awaited_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/tcsa_pkg.sv
rtl/tcsa_div.sv
rtl/tcsa_dp.sv
rtl/tcsa_ctrl.sv
rtl/trace_cycle_stamp_anchor_core.sv
test/testbench.sv
